### hw/rtl/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types, token kinds, error codes and character classes for the
// expression character tokenizer.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int Q_DEPTH       = 2;
  localparam int Q_AW          = $clog2(Q_DEPTH);

  localparam logic [3:0] K_IDENT  = 4'd0;
  localparam logic [3:0] K_OP     = 4'd1;
  localparam logic [3:0] K_INT    = 4'd2;
  localparam logic [3:0] K_REAL   = 4'd3;
  localparam logic [3:0] K_STR    = 4'd4;
  localparam logic [3:0] K_CHAR   = 4'd5;
  localparam logic [3:0] K_LPAREN = 4'd6;
  localparam logic [3:0] K_RPAREN = 4'd7;
  localparam logic [3:0] K_LBRACK = 4'd8;
  localparam logic [3:0] K_RBRACK = 4'd9;
  localparam logic [3:0] K_COMMA  = 4'd10;
  localparam logic [3:0] K_END    = 4'd11;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_BAD_CHAR = 3'd1;
  localparam logic [2:0] E_UNTERM   = 3'd2;
  localparam logic [2:0] E_BAD_OP   = 3'd3;
  localparam logic [2:0] E_OVERFLOW = 3'd4;

  localparam logic [7:0] C_QUOTE  = 8'h27;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_MINUS  = 8'h2d;
  localparam logic [7:0] C_DOT    = 8'h2e;
  localparam logic [7:0] C_USCORE = 8'h5f;
  localparam logic [7:0] C_DOLLAR = 8'h24;

  // floor(2^63 / 10); one less applies when the new digit is nine
  localparam logic [63:0] ACC_LIMIT = 64'd922337203685477580;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_OPER, M_MINUS, M_INTD, M_REALD, M_STR, M_CHQ1, M_CHQ2
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [63:0] int_value;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        stream_done;
  } tok_t;

  typedef struct packed {
    tok_t [2:0] r;
    logic [1:0] n;
  } grp_t;

  function automatic grp_t push(grp_t g, tok_t t);
    grp_t o;
    o = g;
    if (o.n != 2'd3) begin
      o.r[o.n] = t;
      o.n = o.n + 2'd1;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic ident_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == C_QUOTE) || (c == C_DOT) ||
           (c == C_USCORE);
  endfunction

  function automatic logic op_char(logic [7:0] c);
    return (c == 8'h2b) || (c == C_MINUS) || (c == 8'h2a) || (c == 8'h2f) ||
           (c == 8'h25) || (c == 8'h3d) || (c == 8'h3e) || (c == 8'h3c) ||
           (c == 8'h26) || (c == 8'h7c) || (c == 8'h5e) || (c == 8'h7e) ||
           (c == C_DOT) || (c == C_DOLLAR) || (c == 8'h21);
  endfunction

endpackage

### hw/rtl/expression_char_tokenizer.sv
// ----------------------------------------------------------------------------
// expression_char_tokenizer
// Streams expression text one character per transaction and emits tokens.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the output is not stalled and each
// character gives at most one token; up to three tokens closed by one character
// are handed out in turn. The queue registers each group; the output reads its head.
// Reset: scanner idle at offset zero, queue empty.
module expression_char_tokenizer #(
  parameter int POS_WIDTH = ect_pkg::POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [15:0] start_pos,
  output logic [15:0] token_len,
  output logic signed [63:0] int_value,
  output logic [7:0]  char_value,
  output logic [2:0]  error_code,
  output logic        stream_done,
  output logic        last_of_run
);
  import ect_pkg::*;

  logic in_fire, push_en, full, not_empty, pop;
  grp_t push_grp, head;
  tok_t tok;

  assign in_stall = full;
  assign in_fire  = in_valid && !in_stall;

  ect_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk, .rst, .in_fire, .ch, .final_char, .push_en, .push_grp
  );

  ect_queue u_queue (
    .clk, .rst, .push_en, .push_grp, .full, .not_empty, .head, .pop
  );

  ect_back u_back (
    .clk, .rst, .not_empty, .head, .pop, .out_valid, .out_stall, .tok, .last_of_run
  );

  assign kind        = tok.kind;
  assign start_pos   = tok.start_pos;
  assign token_len   = tok.token_len;
  assign int_value   = tok.int_value;
  assign char_value  = tok.char_value;
  assign error_code  = tok.error_code;
  assign stream_done = tok.stream_done;

endmodule

### hw/rtl/ect_front.sv
// ----------------------------------------------------------------------------
// ect_front
// Character scanner: classifies each character, tracks the open token and
// pushes the group of tokens that character completes into the queue.
// ----------------------------------------------------------------------------
module ect_front #(
  parameter int POS_WIDTH = ect_pkg::POS_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [7:0]    ch,
  input  logic          final_char,
  output logic          push_en,
  output ect_pkg::grp_t push_grp
);
  import ect_pkg::*;

  typedef logic [POS_WIDTH-1:0] pos_t;

  mode_t       mode, mode_next;
  pos_t        tstart, tstart_next;
  pos_t        tlen, tlen_next;
  pos_t        cpos, cpos_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic        ovf, ovf_next;
  logic [7:0]  held, held_next;
  logic        skip, skip_next;
  logic        do_idle;
  logic [63:0] acc_dig;
  logic [63:0] lim;
  grp_t        g;

  function automatic pos_t sat(pos_t v);
    return (v == '1) ? v : pos_t'(v + 1'b1);
  endfunction

  function automatic tok_t mk(logic [3:0] k, pos_t s, pos_t l, logic [63:0] iv,
                              logic [7:0] cv, logic [2:0] e, logic d);
    tok_t t;
    t.kind        = k;
    t.start_pos   = 16'(s);
    t.token_len   = 16'(l);
    t.int_value   = iv;
    t.char_value  = cv;
    t.error_code  = e;
    t.stream_done = d;
    return t;
  endfunction

  function automatic logic int_bad(logic o, logic n, logic [63:0] a);
    return o || (!n && a[63]);
  endfunction

  function automatic logic [63:0] int_val(logic n, logic [63:0] a);
    return n ? (64'd0 - a) : a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      tstart <= '0;
      tlen   <= '0;
      cpos   <= '0;
      acc    <= '0;
      neg    <= 1'b0;
      ovf    <= 1'b0;
      held   <= '0;
      skip   <= 1'b0;
    end else begin
      mode   <= mode_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      cpos   <= cpos_next;
      acc    <= acc_next;
      neg    <= neg_next;
      ovf    <= ovf_next;
      held   <= held_next;
      skip   <= skip_next;
    end
  end

  always_comb begin
    mode_next   = mode;
    tstart_next = tstart;
    tlen_next   = tlen;
    cpos_next   = cpos;
    acc_next    = acc;
    neg_next    = neg;
    ovf_next    = ovf;
    held_next   = held;
    skip_next   = skip;
    g           = '0;
    do_idle     = 1'b0;
    acc_dig     = {60'd0, ch[3:0]};
    lim         = (ch[3:0] == 4'd9) ? (ACC_LIMIT - 64'd1) : ACC_LIMIT;

    if (in_fire && !skip) begin
      unique case (mode)
        M_IDENT: begin
          if (ident_char(ch)) begin
            tlen_next = sat(tlen);
          end else begin
            g = push(g, mk(K_IDENT, tstart, tlen, '0, '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
            do_idle   = 1'b1;
          end
        end
        M_OPER: begin
          if (op_char(ch)) begin
            tlen_next = sat(tlen);
          end else begin
            g = push(g, mk(K_OP, tstart, tlen, '0, '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
            do_idle   = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(ch)) begin
            mode_next = M_INTD;
            neg_next  = 1'b1;
            ovf_next  = 1'b0;
            acc_next  = acc_dig;
            tlen_next = sat(tlen);
          end else if (op_char(ch)) begin
            mode_next = M_OPER;
            tlen_next = sat(tlen);
          end else begin
            g = push(g, mk(K_OP, tstart, tlen, '0, '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
            do_idle   = 1'b1;
          end
        end
        M_INTD: begin
          if (is_digit(ch)) begin
            if (!ovf) begin
              if (acc > lim) ovf_next = 1'b1;
              else acc_next = (acc << 3) + (acc << 1) + acc_dig;
            end
            tlen_next = sat(tlen);
          end else if (ch == C_DOT) begin
            mode_next = M_REALD;
            tlen_next = sat(tlen);
          end else if (int_bad(ovf, neg, acc)) begin
            g = push(g, mk(K_END, tstart, '0, '0, '0, E_OVERFLOW, 1'b1));
            skip_next = 1'b1;
            mode_next = M_IDLE;
          end else begin
            g = push(g, mk(K_INT, tstart, tlen, int_val(neg, acc), '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
            do_idle   = 1'b1;
          end
        end
        M_REALD: begin
          if (is_digit(ch)) begin
            tlen_next = sat(tlen);
          end else begin
            g = push(g, mk(K_REAL, tstart, tlen, '0, '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
            do_idle   = 1'b1;
          end
        end
        M_STR: begin
          tlen_next = sat(tlen);
          if (ch == C_DQUOTE) begin
            g = push(g, mk(K_STR, tstart, sat(tlen), '0, '0, E_NONE, 1'b0));
            mode_next = M_IDLE;
          end
        end
        M_CHQ1: begin
          held_next = ch;
          mode_next = M_CHQ2;
        end
        M_CHQ2: begin
          if (ch == C_QUOTE) begin
            g = push(g, mk(K_CHAR, tstart, pos_t'(1), '0, held, E_NONE, 1'b0));
          end else begin
            g = push(g, mk(K_END, tstart, '0, '0, '0, E_BAD_CHAR, 1'b1));
            skip_next = 1'b1;
          end
          mode_next = M_IDLE;
        end
        default: begin
          mode_next = M_IDLE;
          do_idle   = 1'b1;
        end
      endcase

      // start a new token from this character
      if (do_idle && !is_space(ch)) begin
        if (ch == 8'h28) begin
          g = push(g, mk(K_LPAREN, cpos, pos_t'(1), '0, '0, E_NONE, 1'b0));
        end else if (ch == 8'h29) begin
          g = push(g, mk(K_RPAREN, cpos, pos_t'(1), '0, '0, E_NONE, 1'b0));
        end else if (ch == 8'h5b) begin
          g = push(g, mk(K_LBRACK, cpos, pos_t'(1), '0, '0, E_NONE, 1'b0));
        end else if (ch == 8'h5d) begin
          g = push(g, mk(K_RBRACK, cpos, pos_t'(1), '0, '0, E_NONE, 1'b0));
        end else if (ch == 8'h2c) begin
          g = push(g, mk(K_COMMA, cpos, pos_t'(1), '0, '0, E_NONE, 1'b0));
        end else if (ch == C_QUOTE || ch == C_DQUOTE || is_digit(ch) ||
                     ch == C_MINUS || ch == C_USCORE || is_alpha(ch) || op_char(ch)) begin
          tstart_next = cpos;
          tlen_next   = pos_t'(1);
          if (ch == C_QUOTE) begin
            mode_next = M_CHQ1;
          end else if (ch == C_DQUOTE) begin
            mode_next = M_STR;
          end else if (is_digit(ch)) begin
            mode_next = M_INTD;
            neg_next  = 1'b0;
            ovf_next  = 1'b0;
            acc_next  = acc_dig;
          end else if (ch == C_MINUS) begin
            mode_next = M_MINUS;
          end else if (is_alpha(ch) || ch == C_USCORE) begin
            mode_next = M_IDENT;
          end else begin
            mode_next = M_OPER;
          end
        end else begin
          g = push(g, mk(K_END, cpos, '0, '0, '0, E_BAD_OP, 1'b1));
          skip_next = 1'b1;
          mode_next = M_IDLE;
        end
      end

      cpos_next = sat(cpos);

      // close the open token, then End unless that raised an error
      if (final_char && !skip_next) begin
        unique case (mode_next)
          M_IDENT:
            g = push(g, mk(K_IDENT, tstart_next, tlen_next, '0, '0, E_NONE, 1'b0));
          M_OPER, M_MINUS:
            g = push(g, mk(K_OP, tstart_next, tlen_next, '0, '0, E_NONE, 1'b0));
          M_REALD:
            g = push(g, mk(K_REAL, tstart_next, tlen_next, '0, '0, E_NONE, 1'b0));
          M_INTD: begin
            if (int_bad(ovf_next, neg_next, acc_next)) begin
              g = push(g, mk(K_END, tstart_next, '0, '0, '0, E_OVERFLOW, 1'b1));
              skip_next = 1'b1;
            end else begin
              g = push(g, mk(K_INT, tstart_next, tlen_next, int_val(neg_next, acc_next),
                             '0, E_NONE, 1'b0));
            end
          end
          M_STR: begin
            g = push(g, mk(K_END, tstart_next, '0, '0, '0, E_UNTERM, 1'b1));
            skip_next = 1'b1;
          end
          M_CHQ1, M_CHQ2: begin
            g = push(g, mk(K_END, tstart_next, '0, '0, '0, E_BAD_CHAR, 1'b1));
            skip_next = 1'b1;
          end
          default: ;
        endcase
        if (!skip_next) begin
          g = push(g, mk(K_END, cpos_next, '0, '0, '0, E_NONE, 1'b1));
        end
      end
    end

    // last character: start a fresh string
    if (in_fire && final_char) begin
      mode_next   = M_IDLE;
      tstart_next = '0;
      tlen_next   = '0;
      cpos_next   = '0;
      acc_next    = '0;
      neg_next    = 1'b0;
      ovf_next    = 1'b0;
      held_next   = '0;
      skip_next   = 1'b0;
    end
  end

  assign push_en  = in_fire && (g.n != 2'd0);
  assign push_grp = g;

endmodule

### hw/rtl/ect_queue.sv
// ----------------------------------------------------------------------------
// ect_queue
// Short queue of token groups between the scanner and the output side.
// ----------------------------------------------------------------------------
module ect_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_en,
  input  ect_pkg::grp_t push_grp,
  output logic          full,
  output logic          not_empty,
  output ect_pkg::grp_t head,
  input  logic          pop
);
  import ect_pkg::*;

  grp_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_AW:0]   count;
  logic            do_push, do_pop;

  assign full      = (count == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push_en && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

endmodule

### hw/rtl/ect_back.sv
// ----------------------------------------------------------------------------
// ect_back
// Output side: hands out the tokens of the head group one per transaction
// and marks the last one of each group.
// ----------------------------------------------------------------------------
module ect_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  ect_pkg::grp_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ect_pkg::tok_t tok,
  output logic          last_of_run
);
  import ect_pkg::*;

  logic [1:0] sel;
  logic       fire;

  assign out_valid   = not_empty;
  assign fire        = out_valid && !out_stall;
  assign last_of_run = (sel == head.n - 2'd1);
  assign tok         = head.r[sel];
  assign pop         = fire && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (fire) begin
      sel <= last_of_run ? 2'd0 : sel + 2'd1;
    end
  end

endmodule

### tb/sv/tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tokenizer_checker
// Watches both channels of the expression tokenizer, predicts the tokens
// each accepted character closes and compares them in order.
// ----------------------------------------------------------------------------
module tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        final_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  kind,
  input  logic [15:0] start_pos,
  input  logic [15:0] token_len,
  input  logic [63:0] int_value,
  input  logic [7:0]  char_value,
  input  logic [2:0]  error_code,
  input  logic        stream_done,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending
);
  import ect_pkg::*;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [63:0] int_value;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        stream_done;
    logic        last_of_run;
  } token_rec_t;

  localparam logic [15:0] POS_SAT = 16'hffff;
  localparam logic [63:0] INT_MIN_MAG = 64'h8000000000000000;

  token_rec_t tokens_due[$];
  token_rec_t step_toks[$];

  mode_t       mode;
  logic [15:0] tok_start, tok_len, cur_pos;
  logic [63:0] acc;
  logic        neg, ovf, skip;
  logic [7:0]  held;

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == POS_SAT) ? v : v + 16'd1;
  endfunction

  function automatic logic dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic opc(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
           c == ">" || c == "<" || c == "&" || c == "|" || c == "^" || c == "~" ||
           c == "." || c == "$" || c == "!";
  endfunction

  function automatic void put(logic [3:0] k, logic [15:0] s, logic [15:0] l,
                              logic [63:0] iv, logic [7:0] cv, logic [2:0] e, logic d);
    token_rec_t t;
    t.kind = k; t.start_pos = s; t.token_len = l; t.int_value = iv;
    t.char_value = cv; t.error_code = e; t.stream_done = d; t.last_of_run = 1'b0;
    if (step_toks.size() < 3) step_toks = {step_toks, t};
  endfunction

  function automatic void fail_tok(logic [2:0] e, logic [15:0] s);
    put(K_END, s, 16'd0, 64'd0, 8'd0, e, 1'b1);
    skip = 1'b1;
    mode = M_IDLE;
  endfunction

  task automatic close_tok(logic [3:0] k);
    put(k, tok_start, tok_len, 64'd0, 8'd0, E_NONE, 1'b0);
    mode = M_IDLE;
  endtask

  function automatic logic close_int();
    if (ovf || (!neg && acc >= INT_MIN_MAG)) begin
      fail_tok(E_OVERFLOW, tok_start);
      return 1'b0;
    end
    put(K_INT, tok_start, tok_len, neg ? 64'd0 - acc : acc, 8'd0, E_NONE, 1'b0);
    mode = M_IDLE;
    return 1'b1;
  endfunction

  task automatic open_tok(mode_t m, logic [15:0] p);
    mode = m; tok_start = p; tok_len = 16'd1;
  endtask

  task automatic start_char(logic [7:0] c, logic [15:0] p);
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    case (c)
      "(": begin put(K_LPAREN, p, 16'd1, 64'd0, 8'd0, E_NONE, 1'b0); return; end
      ")": begin put(K_RPAREN, p, 16'd1, 64'd0, 8'd0, E_NONE, 1'b0); return; end
      "[": begin put(K_LBRACK, p, 16'd1, 64'd0, 8'd0, E_NONE, 1'b0); return; end
      "]": begin put(K_RBRACK, p, 16'd1, 64'd0, 8'd0, E_NONE, 1'b0); return; end
      ",": begin put(K_COMMA, p, 16'd1, 64'd0, 8'd0, E_NONE, 1'b0); return; end
      default: ;
    endcase
    if (c == C_QUOTE) open_tok(M_CHQ1, p);
    else if (c == C_DQUOTE) open_tok(M_STR, p);
    else if (dig(c)) begin
      open_tok(M_INTD, p); neg = 1'b0; ovf = 1'b0; acc = 64'(c - "0");
    end else if (c == C_MINUS) open_tok(M_MINUS, p);
    else if (alpha(c) || c == C_USCORE) open_tok(M_IDENT, p);
    else if (opc(c)) open_tok(M_OPER, p);
    else fail_tok(E_BAD_OP, p);
  endtask

  task automatic scan_char(logic [7:0] c, logic [15:0] p);
    logic [63:0] d;
    case (mode)
      M_IDENT: begin
        if (alpha(c) || dig(c) || c == C_QUOTE || c == C_DOT || c == C_USCORE) begin
          tok_len = sat_up(tok_len); return;
        end
        close_tok(K_IDENT);
      end
      M_OPER: begin
        if (opc(c)) begin tok_len = sat_up(tok_len); return; end
        close_tok(K_OP);
      end
      M_MINUS: begin
        if (dig(c)) begin
          mode = M_INTD; neg = 1'b1; ovf = 1'b0; acc = 64'(c - "0");
          tok_len = sat_up(tok_len); return;
        end
        if (opc(c)) begin mode = M_OPER; tok_len = sat_up(tok_len); return; end
        close_tok(K_OP);
      end
      M_INTD: begin
        if (dig(c)) begin
          d = 64'(c - "0");
          if (!ovf) begin
            if (acc > (INT_MIN_MAG - d) / 64'd10) ovf = 1'b1;
            else acc = acc * 64'd10 + d;
          end
          tok_len = sat_up(tok_len); return;
        end
        if (c == C_DOT) begin mode = M_REALD; tok_len = sat_up(tok_len); return; end
        if (!close_int()) return;
      end
      M_REALD: begin
        if (dig(c)) begin tok_len = sat_up(tok_len); return; end
        close_tok(K_REAL);
      end
      M_STR: begin
        tok_len = sat_up(tok_len);
        if (c == C_DQUOTE) close_tok(K_STR);
        return;
      end
      M_CHQ1: begin held = c; mode = M_CHQ2; return; end
      M_CHQ2: begin
        if (c == C_QUOTE) begin
          put(K_CHAR, tok_start, 16'd1, 64'd0, held, E_NONE, 1'b0); mode = M_IDLE;
        end else fail_tok(E_BAD_CHAR, tok_start);
        return;
      end
      default: mode = M_IDLE;
    endcase
    start_char(c, p);
  endtask

  task automatic end_string();
    case (mode)
      M_IDENT: close_tok(K_IDENT);
      M_OPER, M_MINUS: close_tok(K_OP);
      M_REALD: close_tok(K_REAL);
      M_INTD: if (!close_int()) return;
      M_STR: begin fail_tok(E_UNTERM, tok_start); return; end
      M_CHQ1, M_CHQ2: begin fail_tok(E_BAD_CHAR, tok_start); return; end
      default: ;
    endcase
    put(K_END, cur_pos, 16'd0, 64'd0, 8'd0, E_NONE, 1'b1);
  endtask

  task automatic clear_string();
    mode = M_IDLE; tok_start = '0; tok_len = '0; cur_pos = '0; acc = '0;
    neg = 1'b0; ovf = 1'b0; held = '0; skip = 1'b0;
  endtask

  task automatic predict_char(logic [7:0] c, logic fin);
    logic [15:0] p;
    p = cur_pos;
    step_toks.delete();
    if (!skip) begin
      scan_char(c, p);
      cur_pos = sat_up(p);
      if (fin && !skip) end_string();
    end
    if (fin) clear_string();
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    tokens_due = {tokens_due, step_toks};
  endtask

  task automatic compare_token();
    token_rec_t e;
    if (tokens_due.size() == 0) begin
      $display("%0t: unexpected token kind %0d start %0d", $time, kind, start_pos);
      fail_count++;
      return;
    end
    e = tokens_due.pop_front();
    if (kind !== e.kind || start_pos !== e.start_pos || token_len !== e.token_len ||
        int_value !== e.int_value || char_value !== e.char_value ||
        error_code !== e.error_code || stream_done !== e.stream_done ||
        last_of_run !== e.last_of_run) begin
      $display("%0t: mismatch expected k%0d s%0d l%0d i%0d c%0d e%0d d%0d r%0d", $time,
               e.kind, e.start_pos, e.token_len, $signed(e.int_value), e.char_value,
               e.error_code, e.stream_done, e.last_of_run);
      $display("%0t:          actual   k%0d s%0d l%0d i%0d c%0d e%0d d%0d r%0d", $time,
               kind, start_pos, token_len, $signed(int_value), char_value,
               error_code, stream_done, last_of_run);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_string();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      tokens_due.delete();
    end else begin
      if (out_valid && !out_stall) compare_token();
      if (in_valid && !in_stall) predict_char(ch, final_char);
    end
    pending = tokens_due.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives expression strings into the tokenizer, directed ones first and
// then random well-formed and broken strings, with idle and stall bursts.
// ----------------------------------------------------------------------------
module testbench;
  import ect_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_stall, final_char, out_valid, out_stall;
  logic [7:0]  ch;
  logic [3:0]  kind;
  logic [15:0] start_pos, token_len;
  logic signed [63:0] int_value;
  logic [7:0]  char_value;
  logic [2:0]  error_code;
  logic        stream_done, last_of_run;
  int          fail_count, pending;
  logic        calm;
  logic        hold_rx;
  int          sent;

  expression_char_tokenizer uut (.*);

  tokenizer_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("expression_char_tokenizer verification failed");
    $finish;
  end

  // receiver: random stall bursts, quiet near the end, one long hold-off
  initial begin
    int n;
    logic hold_taken;
    out_stall = 0;
    hold_taken = 0;
    @(negedge clk);
    forever begin
      if (hold_rx && !hold_taken) begin
        hold_taken = 1;
        out_stall <= 1;
        for (n = 0; n < 60; n++) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic fin);
    int g;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      g = $urandom_range(1, 9);
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    ch <= c;
    final_char <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    in_valid <= 0;
  endtask

  function automatic string rand_piece();
    string s;
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0: s = $sformatf("x%0d_a.b'", $urandom_range(0, 99));
      1: s = ">>=";
      2: s = $sformatf("%0d", $urandom);
      3: s = $sformatf("-%0d", $urandom_range(0, 999));
      4: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9));
      5: s = "\"ab c\"";
      6: begin s = "'x'"; s[1] = 8'($urandom); end
      7: s = "(";
      8: s = ")[],";
      9: s = "-+";
      10: s = "9223372036854775807";
      default: s = "  \t";
    endcase
    return s;
  endfunction

  initial begin
    string s;
    int parts;
    rst = 1; in_valid = 0; ch = 0; final_char = 0; calm = 0; hold_rx = 0; sent = 0;
    repeat (4) @(negedge clk);
    rst = 0;
    send_text("a_1+(b.c,[-7])");
    send_text("-9223372036854775808 9223372036854775808");
    send_text("3.x 12. 'q' \"s\"");
    send_text("- -x ~$!");
    send_text("'ab");
    send_text("\"open");
    send_text("1#xyz");
    send_text("'");
    send_char(8'hff, 0); send_char(8'h00, 0); send_char(8'h7f, 1);
    send_char(8'h80, 1);
    send_text("99999999999999999999");
    // fill the block while the receiver holds off
    hold_rx = 1;
    send_text("(,)[](,)[](,)[],,,,");
    // drain before going on
    while (pending != 0) @(negedge clk);
    while (sent < 320) begin
      s = "";
      parts = $urandom_range(1, 6);
      for (int i = 0; i < parts; i++) s = {s, rand_piece(), " "};
      if ($urandom_range(0, 9) == 0) begin
        s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
      end
      if (sent > 260) calm = 1;
      send_text(s);
    end
    in_valid <= 0;
    fork
      begin while (pending != 0) @(negedge clk); end
      begin repeat (20000) @(negedge clk); end
    join_any
    disable fork;
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("expression_char_tokenizer verification clean");
    end else begin
      $display("expression_char_tokenizer verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ect_pkg.sv
hw/rtl/ect_front.sv
hw/rtl/ect_queue.sv
hw/rtl/ect_back.sv
hw/rtl/expression_char_tokenizer.sv
tb/sv/tokenizer_checker.sv
tb/sv/testbench.sv
